// ===== rtl/rap_pkg.sv =====
// ----------------------------------------------------------------------------
// rap_pkg
// Shared types, constants and register codes of the record access page
// splitter.
// ----------------------------------------------------------------------------
package rap_pkg;

   localparam int MAX_RECORDS = 64;
   localparam int REG_HIGH    = 512;
   localparam int DIV_STEPS   = 16;

   localparam logic [1:0] CSR_RECORDS_PER_PAGE = 2'd0;
   localparam logic [1:0] CSR_RECORD_BYTES     = 2'd1;
   localparam logic [1:0] CSR_FIRST_PAGE       = 2'd2;

   typedef struct packed {
      logic        func;
      logic [15:0] start_record;
      logic [6:0]  record_count;
   } req_type;

   typedef struct packed {
      logic        access_kind;
      logic [7:0]  page;
      logic [8:0]  page_offset;
      logic [9:0]  byte_length;
      logic [14:0] buffer_offset;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [9:0] records_per_page;
      logic [9:0] record_bytes;
      logic [7:0] first_page;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic emit_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic div_last;
      logic chunk_last;
   } dp_status_type;

   function automatic logic [9:0] clamp_reg(input logic [9:0] value);
      logic [9:0] result;
      if (value == 10'd0) begin
         result = 10'd1;
      end else if (value > 10'(REG_HIGH)) begin
         result = 10'(REG_HIGH);
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

// ===== rtl/rap_ctrl.sv =====
// ----------------------------------------------------------------------------
// rap_ctrl
// Sequencer of the splitter: takes an item, runs the divider, then steps
// through the page chunks as the result side takes them.
// ----------------------------------------------------------------------------
module rap_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rap_pkg::dp_status_type status,
   output rap_pkg::ctrl_cmd_type  cmd
);
   import rap_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.count_zero) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready && status.chunk_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd.load      = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.emit_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid && !status.count_zero;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_step = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/rap_dp.sv =====
// ----------------------------------------------------------------------------
// rap_dp
// Datapath of the splitter: restoring divider for the start page and slot,
// and the chunk registers that produce one command per page.
// ----------------------------------------------------------------------------
module rap_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  rap_pkg::cfg_type       cfg,
   input  rap_pkg::req_type       req_payload,
   input  rap_pkg::ctrl_cmd_type  cmd,
   output rap_pkg::dp_status_type status,
   output rap_pkg::rsp_type       rsp_payload
);
   import rap_pkg::*;

   logic        kind_ff;
   logic [6:0]  remaining_ff;
   logic [6:0]  remaining_in;
   logic [15:0] quot_ff;
   logic [15:0] quot_in;
   logic [9:0]  rem_ff;
   logic [9:0]  rem_in;
   logic [3:0]  step_ff;
   logic [7:0]  page_ff;
   logic [8:0]  slot_ff;
   logic [14:0] buf_pos_ff;

   logic [6:0]  count_sat;
   logic [10:0] trial;
   logic [10:0] trial_diff;
   logic        quot_bit;
   logic [9:0]  avail;
   logic [6:0]  chunk;
   logic [18:0] offset_prod;
   logic [16:0] length_prod;

   assign count_sat = (req_payload.record_count > 7'(MAX_RECORDS)) ?
                      7'(MAX_RECORDS) : req_payload.record_count;

   assign trial      = {rem_ff, quot_ff[15]};
   assign trial_diff = trial - {1'b0, cfg.records_per_page};
   assign quot_bit   = (trial >= {1'b0, cfg.records_per_page});
   assign rem_in     = quot_bit ? trial_diff[9:0] : trial[9:0];
   assign quot_in    = {quot_ff[14:0], quot_bit};

   assign avail = cfg.records_per_page - {1'b0, slot_ff};
   assign chunk = ({3'd0, remaining_ff} < avail) ? remaining_ff : avail[6:0];
   assign remaining_in = remaining_ff - chunk;

   assign offset_prod = {10'd0, slot_ff} * {9'd0, cfg.record_bytes};
   assign length_prod = {10'd0, chunk} * {7'd0, cfg.record_bytes};

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.load) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff      <= req_payload.func;
         remaining_ff <= count_sat;
         quot_ff      <= req_payload.start_record;
         rem_ff       <= '0;
         buf_pos_ff   <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         if (status.div_last) begin
            page_ff <= quot_in[7:0] + cfg.first_page;
            slot_ff <= rem_in[8:0];
         end
      end else if (cmd.emit_step) begin
         remaining_ff <= remaining_in;
         page_ff      <= page_ff + 8'd1;
         slot_ff      <= '0;
         buf_pos_ff   <= buf_pos_ff + length_prod[14:0];
      end
   end

   assign status.count_zero = (count_sat == 7'd0);
   assign status.div_last   = (step_ff == 4'(DIV_STEPS - 1));
   assign status.chunk_last = (remaining_in == 7'd0);

   assign rsp_payload.access_kind   = kind_ff;
   assign rsp_payload.page          = page_ff;
   assign rsp_payload.page_offset   = offset_prod[8:0];
   assign rsp_payload.byte_length   = length_prod[9:0];
   assign rsp_payload.buffer_offset = buf_pos_ff;
   assign rsp_payload.last          = status.chunk_last;

endmodule

// ===== rtl/record_access_page_splitter.sv =====
// ----------------------------------------------------------------------------
// record_access_page_splitter
// Splits a request for a run of fixed-size records into one flash command
// per page touched.
// ----------------------------------------------------------------------------
// An accepted item with a nonzero record count runs through the restoring
// divider, one quotient bit per cycle, to find the start page and slot, and
// then steps through its page chunks while rsp_ready is high; no new item
// is taken until the last chunk of a request has been taken. An item with a
// record count of zero is taken from the idle state and produces no result.
// Configuration writes are always accepted and should be made only while
// the block is idle.
module record_access_page_splitter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rap_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rap_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [9:0]       csr_data
);
   import rap_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RECORDS_PER_PAGE: cfg_in.records_per_page = clamp_reg(csr_data);
            CSR_RECORD_BYTES:     cfg_in.record_bytes     = clamp_reg(csr_data);
            CSR_FIRST_PAGE:       cfg_in.first_page       = csr_data[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.records_per_page <= 10'd1;
         cfg_ff.record_bytes     <= 10'd1;
         cfg_ff.first_page       <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rap_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/rap_checker.sv =====
// ----------------------------------------------------------------------------
// rap_checker
// Port-level checks of the splitter, bound to the top level.
// ----------------------------------------------------------------------------
module rap_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rap_pkg::rsp_type rsp_payload
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Result item changed while stalled.");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("Result offered in the cycle after an item was taken.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("New item taken while a request is still being split.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last |=> rsp_valid)
      else $error("Request ended without a last chunk.");

endmodule

bind record_access_page_splitter rap_checker u_rap_checker (.*);
